// ===== rtl/pqa_pkg.sv =====
// ----------------------------------------------------------------------------
// pqa_pkg
// Shared types, constants and helpers of the plane quadric accumulator.
// ----------------------------------------------------------------------------
package pqa_pkg;

   localparam int POS_FRAC_BITS = 16;
   localparam int THR_UP        = (2 * POS_FRAC_BITS >= 32) ? 2 * POS_FRAC_BITS - 32 : 0;
   localparam int THR_DN        = (2 * POS_FRAC_BITS >= 32) ? 0 : 32 - 2 * POS_FRAC_BITS;
   localparam int DOT_SHIFT     = POS_FRAC_BITS - 2;
   localparam int NUM_TERMS     = 10;

   localparam logic [31:0] MIN_CROSS_RESET = 32'd4295;
   localparam logic [63:0] SUM_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SUM_MIN         = 64'h8000_0000_0000_0000;

   // operand selects of one quadric term
   localparam logic [1:0] SEL_NX = 2'd0;
   localparam logic [1:0] SEL_NY = 2'd1;
   localparam logic [1:0] SEL_NZ = 2'd2;
   localparam logic [1:0] SEL_DQ = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CROSS_MUL,
      ST_CROSS_ACC,
      ST_MAX,
      ST_NORM,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT,
      ST_LEN,
      ST_DIV_INIT,
      ST_DIV,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_DQ,
      ST_TERM_MUL,
      ST_TERM_ACC,
      ST_TERM_FIN,
      ST_TERM_ADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] xsel;
      logic [1:0] ysel;
      logic [5:0] shift;
   } term_sel_type;

   function automatic term_sel_type term_sel(input logic [3:0] t);
      term_sel_type r;
      unique case (t)
         4'd0:    r = '{SEL_NX, SEL_NX, 6'd28};
         4'd1:    r = '{SEL_NX, SEL_NY, 6'd28};
         4'd2:    r = '{SEL_NX, SEL_NZ, 6'd28};
         4'd3:    r = '{SEL_NX, SEL_DQ, 6'd30};
         4'd4:    r = '{SEL_NY, SEL_NY, 6'd28};
         4'd5:    r = '{SEL_NY, SEL_NZ, 6'd28};
         4'd6:    r = '{SEL_NY, SEL_DQ, 6'd30};
         4'd7:    r = '{SEL_NZ, SEL_NZ, 6'd28};
         4'd8:    r = '{SEL_NZ, SEL_DQ, 6'd30};
         4'd9:    r = '{SEL_DQ, SEL_DQ, 6'd32};
         default: r = '{SEL_NX, SEL_NX, 6'd28};
      endcase
      return r;
   endfunction

   // cross length threshold in the units of the cross product length
   function automatic logic [63:0] cross_thr(input logic [31:0] m);
      return ({32'b0, m} << THR_UP) >> THR_DN;
   endfunction

endpackage

// ===== rtl/plane_quadric_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// plane_quadric_accumulator_top
// Error quadric of one vertex: sums the plane quadrics of its triangles.
// ----------------------------------------------------------------------------
// One request is one triangle. The block computes its unit normal and plane
// offset and adds the ten quadric products to saturating Q32.32 sums; on the
// last triangle the sums are sent as one response and cleared. Everything
// runs through one 33x33 signed multiplier, a one-bit-a-cycle normalizing
// shifter, a 32-step square root and a 31-step restoring divider; degenerate
// triangles, zero crosses and short crosses end early, and req_ready is low
// while a triangle is in work. A finished response waits in the output
// register while the next triangle is taken; a last triangle that finds that
// register still full holds until it is taken.
module plane_quadric_accumulator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_corner0_x,
   input  logic signed [31:0] req_corner0_y,
   input  logic signed [31:0] req_corner0_z,
   input  logic signed [31:0] req_corner1_x,
   input  logic signed [31:0] req_corner1_y,
   input  logic signed [31:0] req_corner1_z,
   input  logic signed [31:0] req_corner2_x,
   input  logic signed [31:0] req_corner2_y,
   input  logic signed [31:0] req_corner2_z,
   input  logic               req_is_degenerate,
   input  logic               req_last_triangle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_q_aa,
   output logic signed [63:0] rsp_q_ab,
   output logic signed [63:0] rsp_q_ac,
   output logic signed [63:0] rsp_q_ad,
   output logic signed [63:0] rsp_q_bb,
   output logic signed [63:0] rsp_q_bc,
   output logic signed [63:0] rsp_q_bd,
   output logic signed [63:0] rsp_q_cc,
   output logic signed [63:0] rsp_q_cd,
   output logic signed [63:0] rsp_q_dd,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [31:0] csr_min_cross_length
);

   function automatic logic [31:0] edge_clamp(input logic [31:0] a, input logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({b[31], b}) - $signed({a[31], a});
      if (d > 33'sd2147483647) return 32'h7FFF_FFFF;
      else if (d < -33'sd2147483647) return 32'h8000_0001;
      else return d[31:0];
   endfunction

   pqa_pkg::state_type state_ff, state_in;

   logic signed [31:0] c0_ff [3];
   logic signed [31:0] ea_ff [3];
   logic signed [31:0] eb_ff [3];
   logic               last_ff;
   logic signed [63:0] cr_ff [3];
   logic        [63:0] mg_ff [3];
   logic        [63:0] big_ff;
   logic        [5:0]  sh_ff;
   logic               right_ff;
   logic        [63:0] sq_ff;
   logic        [63:0] sx_ff;
   logic        [63:0] sres_ff;
   logic        [63:0] sbit_ff;
   logic        [31:0] rem_ff;
   logic        [30:0] quo_ff;
   logic        [4:0]  bit_idx_ff;
   logic signed [31:0] nrm_ff [3];
   logic signed [63:0] dot_ff;
   logic        [63:0] dq_mag_ff;
   logic               dq_neg_ff;
   logic       [127:0] acc_ff;
   logic signed [63:0] term_ff;
   logic        [3:0]  term_idx_ff;
   logic        [1:0]  limb_ff;
   logic        [2:0]  idx_ff;
   logic        [1:0]  comp_ff;
   logic signed [63:0] sums_ff [pqa_pkg::NUM_TERMS];
   logic        [63:0] rsp_q_ff [pqa_pkg::NUM_TERMS];
   logic               rsp_valid_ff;
   logic        [31:0] min_len_ff;
   logic signed [65:0] prod_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic        [1:0]  j1, j2;
   logic        [63:0] cmag [3];
   logic        [63:0] cmax;
   logic        [63:0] st_sum;
   logic               st_ge;
   logic        [31:0] root;
   logic        [32:0] div_trial;
   logic               div_ge;
   logic        [30:0] quo_done;
   logic        [63:0] lenq;
   logic        [63:0] dot_mag;
   logic        [63:0] dm;
   pqa_pkg::term_sel_type ts;
   logic        [63:0] xmag, ymag;
   logic               xneg, yneg;
   logic        [127:0] prod_sh;
   logic        [127:0] acc_shr;
   logic        [63:0] rlo;
   logic signed [63:0] cur_sum;
   logic        [64:0] sum65;
   logic        [63:0] sat_sum;
   logic               accept;
   logic               out_load;

   assign req_ready = (state_ff == pqa_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == pqa_pkg::ST_DONE) && last_ff && (!rsp_valid_ff || rsp_ready);

   assign rsp_q_aa = rsp_q_ff[0];
   assign rsp_q_ab = rsp_q_ff[1];
   assign rsp_q_ac = rsp_q_ff[2];
   assign rsp_q_ad = rsp_q_ff[3];
   assign rsp_q_bb = rsp_q_ff[4];
   assign rsp_q_bc = rsp_q_ff[5];
   assign rsp_q_bd = rsp_q_ff[6];
   assign rsp_q_cc = rsp_q_ff[7];
   assign rsp_q_cd = rsp_q_ff[8];
   assign rsp_q_dd = rsp_q_ff[9];

   // cross component pairs
   always_comb begin
      case (idx_ff[2:1])
         2'd0:    begin j1 = 2'd1; j2 = 2'd2; end
         2'd1:    begin j1 = 2'd2; j2 = 2'd0; end
         default: begin j1 = 2'd0; j2 = 2'd1; end
      endcase
   end

   // term operands
   always_comb begin
      ts = pqa_pkg::term_sel(term_idx_ff);
      if (ts.xsel == pqa_pkg::SEL_DQ) begin
         xmag = dq_mag_ff;
         xneg = dq_neg_ff;
      end else begin
         xmag = {32'b0, nrm_ff[ts.xsel][31] ? -nrm_ff[ts.xsel] : nrm_ff[ts.xsel]};
         xneg = nrm_ff[ts.xsel][31];
      end
      if (ts.ysel == pqa_pkg::SEL_DQ) begin
         ymag = dq_mag_ff;
         yneg = dq_neg_ff;
      end else begin
         ymag = {32'b0, nrm_ff[ts.ysel][31] ? -nrm_ff[ts.ysel] : nrm_ff[ts.ysel]};
         yneg = nrm_ff[ts.ysel][31];
      end
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pqa_pkg::ST_CROSS_MUL: begin
            if (!idx_ff[0]) begin
               mul_a = {ea_ff[j1][31], ea_ff[j1]};
               mul_b = {eb_ff[j2][31], eb_ff[j2]};
            end else begin
               mul_a = {ea_ff[j2][31], ea_ff[j2]};
               mul_b = {eb_ff[j1][31], eb_ff[j1]};
            end
         end
         pqa_pkg::ST_SQ_MUL: begin
            mul_a = {1'b0, mg_ff[idx_ff[1:0]][31:0]};
            mul_b = {1'b0, mg_ff[idx_ff[1:0]][31:0]};
         end
         pqa_pkg::ST_DOT_MUL: begin
            mul_a = {nrm_ff[idx_ff[1:0]][31], nrm_ff[idx_ff[1:0]]};
            mul_b = {c0_ff[idx_ff[1:0]][31], c0_ff[idx_ff[1:0]]};
         end
         pqa_pkg::ST_TERM_MUL: begin
            mul_a = {1'b0, limb_ff[1] ? xmag[63:32] : xmag[31:0]};
            mul_b = {1'b0, limb_ff[0] ? ymag[63:32] : ymag[31:0]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cmag[i] = cr_ff[i][63] ? -cr_ff[i] : cr_ff[i];
      end
      cmax = cmag[0];
      if (cmag[1] > cmax) cmax = cmag[1];
      if (cmag[2] > cmax) cmax = cmag[2];

      st_sum    = sres_ff + sbit_ff;
      st_ge     = (sx_ff >= st_sum);
      root      = sres_ff[31:0];
      lenq      = right_ff ? (sres_ff << sh_ff) : (sres_ff >> sh_ff);
      div_trial = {rem_ff, (bit_idx_ff == 5'd30) ? mg_ff[comp_ff][0] : 1'b0};
      div_ge    = (div_trial >= {1'b0, root});
      quo_done  = {quo_ff[29:0], div_ge};

      dot_mag = dot_ff[63] ? -dot_ff : dot_ff;
      dm      = dot_mag >> pqa_pkg::DOT_SHIFT;

      case (limb_ff)
         2'd0:    prod_sh = {64'b0, prod_ff[63:0]};
         2'd3:    prod_sh = {prod_ff[63:0], 64'b0};
         default: prod_sh = {32'b0, prod_ff[63:0], 32'b0};
      endcase
      acc_shr = acc_ff >> ts.shift;
      rlo     = (|acc_shr[127:63]) ? pqa_pkg::SUM_MAX : acc_shr[63:0];

      cur_sum = sums_ff[term_idx_ff];
      sum65   = {cur_sum[63], cur_sum} + {term_ff[63], term_ff};
      if (sum65[64] != sum65[63]) sat_sum = term_ff[63] ? pqa_pkg::SUM_MIN : pqa_pkg::SUM_MAX;
      else sat_sum = sum65[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pqa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pqa_pkg::ST_IDLE: begin
            if (req_valid) state_in = req_is_degenerate ? pqa_pkg::ST_DONE : pqa_pkg::ST_CROSS_MUL;
         end
         pqa_pkg::ST_CROSS_MUL: state_in = pqa_pkg::ST_CROSS_ACC;
         pqa_pkg::ST_CROSS_ACC: begin
            state_in = (idx_ff == 3'd5) ? pqa_pkg::ST_MAX : pqa_pkg::ST_CROSS_MUL;
         end
         pqa_pkg::ST_MAX: state_in = (cmax == 64'd0) ? pqa_pkg::ST_DONE : pqa_pkg::ST_NORM;
         pqa_pkg::ST_NORM: begin
            if (big_ff[63:31] == '0 && big_ff[30]) state_in = pqa_pkg::ST_SQ_MUL;
         end
         pqa_pkg::ST_SQ_MUL: state_in = pqa_pkg::ST_SQ_ACC;
         pqa_pkg::ST_SQ_ACC: begin
            state_in = (idx_ff == 3'd2) ? pqa_pkg::ST_SQRT : pqa_pkg::ST_SQ_MUL;
         end
         pqa_pkg::ST_SQRT: begin
            if (sbit_ff == 64'd1) state_in = pqa_pkg::ST_LEN;
         end
         pqa_pkg::ST_LEN: begin
            if (lenq <= pqa_pkg::cross_thr(min_len_ff) || root == 32'd0) begin
               state_in = pqa_pkg::ST_DONE;
            end else begin
               state_in = pqa_pkg::ST_DIV_INIT;
            end
         end
         pqa_pkg::ST_DIV_INIT: state_in = pqa_pkg::ST_DIV;
         pqa_pkg::ST_DIV: begin
            if (bit_idx_ff == 5'd0) begin
               state_in = (comp_ff == 2'd2) ? pqa_pkg::ST_DOT_MUL : pqa_pkg::ST_DIV_INIT;
            end
         end
         pqa_pkg::ST_DOT_MUL: state_in = pqa_pkg::ST_DOT_ACC;
         pqa_pkg::ST_DOT_ACC: begin
            state_in = (idx_ff == 3'd2) ? pqa_pkg::ST_DQ : pqa_pkg::ST_DOT_MUL;
         end
         pqa_pkg::ST_DQ: state_in = pqa_pkg::ST_TERM_MUL;
         pqa_pkg::ST_TERM_MUL: state_in = pqa_pkg::ST_TERM_ACC;
         pqa_pkg::ST_TERM_ACC: begin
            state_in = (limb_ff == 2'd3) ? pqa_pkg::ST_TERM_FIN : pqa_pkg::ST_TERM_MUL;
         end
         pqa_pkg::ST_TERM_FIN: state_in = pqa_pkg::ST_TERM_ADD;
         pqa_pkg::ST_TERM_ADD: begin
            state_in = (term_idx_ff == 4'(pqa_pkg::NUM_TERMS - 1)) ? pqa_pkg::ST_DONE
                                                                  : pqa_pkg::ST_TERM_MUL;
         end
         pqa_pkg::ST_DONE: begin
            if (!last_ff || out_load) state_in = pqa_pkg::ST_IDLE;
         end
         default: state_in = pqa_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      case (state_ff)
         pqa_pkg::ST_IDLE: begin
            if (accept) begin
               c0_ff[0] <= req_corner0_x;
               c0_ff[1] <= req_corner0_y;
               c0_ff[2] <= req_corner0_z;
               ea_ff[0] <= edge_clamp(req_corner0_x, req_corner1_x);
               ea_ff[1] <= edge_clamp(req_corner0_y, req_corner1_y);
               ea_ff[2] <= edge_clamp(req_corner0_z, req_corner1_z);
               eb_ff[0] <= edge_clamp(req_corner0_x, req_corner2_x);
               eb_ff[1] <= edge_clamp(req_corner0_y, req_corner2_y);
               eb_ff[2] <= edge_clamp(req_corner0_z, req_corner2_z);
               last_ff  <= req_last_triangle;
               idx_ff   <= '0;
            end
         end
         pqa_pkg::ST_CROSS_ACC: begin
            if (!idx_ff[0]) cr_ff[idx_ff[2:1]] <= prod_ff[63:0];
            else cr_ff[idx_ff[2:1]] <= cr_ff[idx_ff[2:1]] - prod_ff[63:0];
            idx_ff <= (idx_ff == 3'd5) ? 3'd0 : idx_ff + 3'd1;
         end
         pqa_pkg::ST_MAX: begin
            for (int i = 0; i < 3; i++) mg_ff[i] <= cmag[i];
            big_ff   <= cmax;
            sh_ff    <= '0;
            right_ff <= 1'b0;
            sq_ff    <= '0;
         end
         pqa_pkg::ST_NORM: begin
            if (big_ff[63:31] != '0) begin
               for (int i = 0; i < 3; i++) mg_ff[i] <= mg_ff[i] >> 1;
               big_ff   <= big_ff >> 1;
               sh_ff    <= sh_ff + 6'd1;
               right_ff <= 1'b1;
            end else if (!big_ff[30]) begin
               for (int i = 0; i < 3; i++) mg_ff[i] <= mg_ff[i] << 1;
               big_ff <= big_ff << 1;
               sh_ff  <= sh_ff + 6'd1;
            end
         end
         pqa_pkg::ST_SQ_ACC: begin
            sq_ff <= sq_ff + prod_ff[63:0];
            if (idx_ff == 3'd2) begin
               idx_ff  <= '0;
               sx_ff   <= sq_ff + prod_ff[63:0];
               sres_ff <= '0;
               sbit_ff <= 64'd1 << 62;
            end else begin
               idx_ff <= idx_ff + 3'd1;
            end
         end
         pqa_pkg::ST_SQRT: begin
            if (st_ge) begin
               sx_ff   <= sx_ff - st_sum;
               sres_ff <= (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_ff <= sres_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
         end
         pqa_pkg::ST_LEN: begin
            comp_ff <= '0;
            dot_ff  <= '0;
         end
         pqa_pkg::ST_DIV_INIT: begin
            rem_ff     <= mg_ff[comp_ff][32:1];
            quo_ff     <= '0;
            bit_idx_ff <= 5'd30;
         end
         pqa_pkg::ST_DIV: begin
            rem_ff     <= div_ge ? 32'(div_trial - {1'b0, root}) : div_trial[31:0];
            quo_ff     <= quo_done;
            bit_idx_ff <= bit_idx_ff - 5'd1;
            if (bit_idx_ff == 5'd0) begin
               nrm_ff[comp_ff] <= cr_ff[comp_ff][63] ? -$signed({1'b0, quo_done})
                                                     : $signed({1'b0, quo_done});
               comp_ff <= comp_ff + 2'd1;
            end
         end
         pqa_pkg::ST_DOT_ACC: begin
            dot_ff <= dot_ff + prod_ff[63:0];
            idx_ff <= (idx_ff == 3'd2) ? 3'd0 : idx_ff + 3'd1;
         end
         pqa_pkg::ST_DQ: begin
            dq_mag_ff   <= dm;
            dq_neg_ff   <= !dot_ff[63] && (dm != 64'd0);
            acc_ff      <= '0;
            term_idx_ff <= '0;
            limb_ff     <= '0;
         end
         pqa_pkg::ST_TERM_ACC: begin
            acc_ff  <= acc_ff + prod_sh;
            limb_ff <= limb_ff + 2'd1;
         end
         pqa_pkg::ST_TERM_FIN: begin
            term_ff <= (xneg ^ yneg) ? -rlo : rlo;
         end
         pqa_pkg::ST_TERM_ADD: begin
            acc_ff      <= '0;
            term_idx_ff <= term_idx_ff + 4'd1;
         end
         default: begin
         end
      endcase
   end

   // sums, response register and csr
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pqa_pkg::NUM_TERMS; i++) sums_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
         min_len_ff   <= pqa_pkg::MIN_CROSS_RESET;
      end else begin
         if (csr_valid) min_len_ff <= csr_min_cross_length;
         if (state_ff == pqa_pkg::ST_TERM_ADD) sums_ff[term_idx_ff] <= sat_sum;
         if (out_load) begin
            for (int i = 0; i < pqa_pkg::NUM_TERMS; i++) begin
               rsp_q_ff[i] <= sums_ff[i];
               sums_ff[i]  <= '0;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // no new request while one is in work
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while busy");

   // square root of a normalized sum lies in [2^30, 2^32)
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pqa_pkg::ST_LEN |-> sres_ff[63:32] == '0 && sres_ff[31:30] != 2'd0)
      else $error("square root out of range");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pqa_pkg::ST_DIV |-> rem_ff < root)
      else $error("divider remainder not below divisor");

   // a pending response is sent once the output register is free
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && state_ff == pqa_pkg::ST_IDLE)
      else $error("response not posted");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the plane quadric accumulator.
// ----------------------------------------------------------------------------
// Triangle requests are sent as vertex fans. Each fan is a run of triangles
// whose final one carries the last flag. A bit-exact fixed-point model runs
// in the bench and keeps its own sums. It queues one expected quadric per
// last triangle, and every response is compared with the oldest entry.
// The run starts with directed corner cases, then covers several threshold
// settings with random fans. It also has a stretch of response back-pressure
// and a pause that lets the block drain.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 400;

   typedef struct {
      logic signed [31:0] c[9];
      bit                 degen;
      bit                 last;
   } triangle_type;

   typedef struct {
      longint q[10];
   } quadric_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_c[9];
   logic               req_is_degenerate;
   logic               req_last_triangle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [63:0] rsp_q[10];
   logic               csr_valid;
   logic               csr_ready;
   logic        [31:0] csr_min_cross_length;

   quadric_type  expected_quadrics[$];
   longint       model_sums[10];
   logic  [31:0] model_min_cross;
   int           errors        = 0;
   int           triangles_sent = 0;
   int           quadrics_seen  = 0;
   int           csr_writes     = 0;
   int           idle_count     = 0;
   bit           hold_request   = 0;

   string field_names[10] = '{"q_aa", "q_ab", "q_ac", "q_ad", "q_bb",
                              "q_bc", "q_bd", "q_cc", "q_cd", "q_dd"};

   plane_quadric_accumulator_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_corner0_x        (req_c[0]),
      .req_corner0_y        (req_c[1]),
      .req_corner0_z        (req_c[2]),
      .req_corner1_x        (req_c[3]),
      .req_corner1_y        (req_c[4]),
      .req_corner1_z        (req_c[5]),
      .req_corner2_x        (req_c[6]),
      .req_corner2_y        (req_c[7]),
      .req_corner2_z        (req_c[8]),
      .req_is_degenerate    (req_is_degenerate),
      .req_last_triangle    (req_last_triangle),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_q_aa             (rsp_q[0]),
      .rsp_q_ab             (rsp_q[1]),
      .rsp_q_ac             (rsp_q[2]),
      .rsp_q_ad             (rsp_q[3]),
      .rsp_q_bb             (rsp_q[4]),
      .rsp_q_bc             (rsp_q[5]),
      .rsp_q_bd             (rsp_q[6]),
      .rsp_q_cc             (rsp_q[7]),
      .rsp_q_cd             (rsp_q[8]),
      .rsp_q_dd             (rsp_q[9]),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_min_cross_length (csr_min_cross_length)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic longint clamp_edge(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
   endfunction

   function automatic longint scaled_product(longint x, longint y, int sh);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] p;
      logic [63:0]  r;
      ma = magnitude(x);
      mb = magnitude(y);
      p  = {64'b0, ma} * {64'b0, mb};
      p  = p >> sh;
      if (p > {64'b0, pqa_pkg::SUM_MAX}) r = pqa_pkg::SUM_MAX;
      else r = p[63:0];
      return ((x < 0) != (y < 0)) ? -$signed(r) : $signed(r);
   endfunction

   function automatic longint add_saturated(longint acc, longint inc);
      logic signed [64:0] s;
      s = 65'(acc) + 65'(inc);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return $signed(pqa_pkg::SUM_MAX);
      if (s < -65'sh0_8000_0000_0000_0000) return $signed(pqa_pkg::SUM_MIN);
      return s[63:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b   = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x   = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   task automatic plane_normal(input longint cr[3], output longint nrm[3]);
      logic [63:0] mg[3];
      logic [63:0] big;
      logic [63:0] sq;
      logic [63:0] root;
      logic [63:0] lenq;
      logic [63:0] thr;
      logic [63:0] q;
      int          rs;
      int          ls;
      rs  = 0;
      ls  = 0;
      sq  = 0;
      for (int i = 0; i < 3; i++) begin
         mg[i]  = magnitude(cr[i]);
         nrm[i] = 0;
      end
      big = mg[0];
      if (mg[1] > big) big = mg[1];
      if (mg[2] > big) big = mg[2];
      if (big == 0) return;
      while ((big >> rs) >= 64'h8000_0000) rs++;
      if (rs == 0) while ((big << ls) < 64'h4000_0000) ls++;
      for (int i = 0; i < 3; i++) begin
         mg[i] = (rs != 0) ? (mg[i] >> rs) : (mg[i] << ls);
         sq    = sq + mg[i] * mg[i];
      end
      root = int_sqrt(sq);
      lenq = (rs != 0) ? (root << rs) : (root >> ls);
      thr  = ({32'b0, model_min_cross} << pqa_pkg::THR_UP) >> pqa_pkg::THR_DN;
      if (lenq <= thr || root == 0) return;
      for (int i = 0; i < 3; i++) begin
         q      = (mg[i] << 30) / root;
         nrm[i] = (cr[i] < 0) ? -$signed(q) : $signed(q);
      end
   endtask

   task automatic accumulate_triangle(input triangle_type t);
      longint      pos[9];
      longint      ea[3];
      longint      eb[3];
      longint      cr[3];
      longint      nrm[3];
      longint      dot;
      longint      dq;
      longint      op[4];
      longint      terms[10];
      quadric_type result;
      for (int i = 0; i < 9; i++) pos[i] = t.c[i];
      for (int i = 0; i < 3; i++) nrm[i] = 0;
      if (!t.degen) begin
         for (int j = 0; j < 3; j++) begin
            ea[j] = clamp_edge(pos[3 + j] - pos[j]);
            eb[j] = clamp_edge(pos[6 + j] - pos[j]);
         end
         cr[0] = ea[1] * eb[2] - ea[2] * eb[1];
         cr[1] = ea[2] * eb[0] - ea[0] * eb[2];
         cr[2] = ea[0] * eb[1] - ea[1] * eb[0];
         plane_normal(cr, nrm);
      end
      dot = nrm[0] * pos[0] + nrm[1] * pos[1] + nrm[2] * pos[2];
      dq  = $signed(magnitude(dot) >> pqa_pkg::DOT_SHIFT);
      if (dot > 0) dq = -dq;
      op = '{nrm[0], nrm[1], nrm[2], dq};
      terms[0] = scaled_product(op[pqa_pkg::SEL_NX], op[pqa_pkg::SEL_NX], 28);
      terms[1] = scaled_product(op[pqa_pkg::SEL_NX], op[pqa_pkg::SEL_NY], 28);
      terms[2] = scaled_product(op[pqa_pkg::SEL_NX], op[pqa_pkg::SEL_NZ], 28);
      terms[3] = scaled_product(op[pqa_pkg::SEL_NX], op[pqa_pkg::SEL_DQ], 30);
      terms[4] = scaled_product(op[pqa_pkg::SEL_NY], op[pqa_pkg::SEL_NY], 28);
      terms[5] = scaled_product(op[pqa_pkg::SEL_NY], op[pqa_pkg::SEL_NZ], 28);
      terms[6] = scaled_product(op[pqa_pkg::SEL_NY], op[pqa_pkg::SEL_DQ], 30);
      terms[7] = scaled_product(op[pqa_pkg::SEL_NZ], op[pqa_pkg::SEL_NZ], 28);
      terms[8] = scaled_product(op[pqa_pkg::SEL_NZ], op[pqa_pkg::SEL_DQ], 30);
      terms[9] = scaled_product(op[pqa_pkg::SEL_DQ], op[pqa_pkg::SEL_DQ], 32);
      for (int i = 0; i < pqa_pkg::NUM_TERMS; i++)
         model_sums[i] = add_saturated(model_sums[i], terms[i]);
      if (t.last) begin
         for (int i = 0; i < pqa_pkg::NUM_TERMS; i++) begin
            result.q[i]   = model_sums[i];
            model_sums[i] = 0;
         end
         expected_quadrics = {expected_quadrics, result};
      end
   endtask

   // ------------------------------------------------------------- drivers

   // all driver tasks start and end just after a falling edge
   task automatic send_triangle(input triangle_type t);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 9; i++) req_c[i] <= t.c[i];
      req_is_degenerate <= t.degen;
      req_last_triangle <= t.last;
      req_valid         <= 1'b1;
      do @(posedge clock); while (!req_ready);
      accumulate_triangle(t);
      triangles_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_quadrics.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_min_cross(input logic [31:0] value);
      wait_drained();
      csr_min_cross_length <= value;
      csr_valid            <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      model_min_cross = value;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0:       return $signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000;
         1:       return $urandom;
         default: begin
            case ($urandom_range(0, 4))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return 0;
               3:       return -1;
               default: return 1;
            endcase
         end
      endcase
   endfunction

   // mode 3 makes a tiny triangle around a random base point
   function automatic triangle_type make_triangle(int mode, bit last);
      triangle_type       t;
      logic signed [31:0] b[3];
      for (int j = 0; j < 3; j++) b[j] = $urandom;
      for (int i = 0; i < 9; i++)
         t.c[i] = (mode == 3) ? b[i % 3] + $signed($urandom_range(0, 6)) - 3
                              : rand_coord(mode);
      t.degen = ($urandom_range(0, 99) < 8);
      t.last  = last;
      return t;
   endfunction

   task automatic send_fan(input int count);
      int mode;
      for (int k = 0; k < count; k++) begin
         mode = $urandom_range(0, 9);
         mode = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
         send_triangle(make_triangle(mode, k == count - 1));
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      triangle_type t;
      t.degen = 0;
      t.last  = 1;
      // unit right triangle in the xy plane, lifted off the origin
      t.c = '{32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh2_0000, 32'sh2_0000,
              32'sh3_0000, 32'sh1_0000, 32'sh3_0000, 32'sh3_0000};
      send_triangle(t);
      // all corners at one point, zero cross
      t.c = '{default: 32'sh1234_5678};
      send_triangle(t);
      // flagged degenerate although well formed
      t.c   = '{0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0};
      t.degen = 1;
      send_triangle(t);
      t.degen = 0;
      // collinear corners
      t.c = '{0, 0, 0, 32'sh1_0000, 32'sh1_0000, 0, 32'sh2_0000, 32'sh2_0000, 0};
      send_triangle(t);
      // cross just under the reset threshold
      t.c = '{0, 0, 0, 32'sd60, 0, 0, 0, 32'sd60, 0};
      send_triangle(t);
      // edges beyond the clamp range
      t.c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
      send_triangle(t);
      // far planes, offset squared saturates the sums
      t.c = '{32'sh7FFF_0000, 0, 0, 32'sh7FFF_0000, 32'sh1_0000, 0,
              32'sh7FFF_0000, 0, 32'sh1_0000};
      t.last = 0;
      repeat (3) send_triangle(t);
      t.c = '{32'sh8000_0000, 0, 0, 32'sh8000_0000, 32'sh1_0000, 0,
              32'sh8000_0000, 0, 32'sh1_0000};
      t.last = 1;
      send_triangle(t);
      // mixed signs driving the off-diagonals negative
      t.c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh7FFF_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
      t.last = 0;
      repeat (3) send_triangle(t);
      t.last = 1;
      send_triangle(t);
      send_fan(4);
      send_triangle(make_triangle(2, 1));
      send_triangle(make_triangle(3, 1));
      send_triangle(make_triangle(1, 1));
   endtask

   task automatic test_threshold_extremes();
      write_min_cross(32'd0);
      send_triangle(make_triangle(3, 1));
      send_fan(3);
      write_min_cross(32'hFFFF_FFFF);
      send_fan(3);
      send_triangle(make_triangle(1, 1));
      write_min_cross(pqa_pkg::MIN_CROSS_RESET);
   endtask

   task automatic test_random_fans(input int total);
      int start;
      while (total > 0) begin
         case ($urandom_range(0, 3))
            0:       write_min_cross($urandom);
            1:       write_min_cross($urandom_range(0, 20000));
            2:       write_min_cross(32'd0);
            default: write_min_cross(32'hFFFF_FFFF);
         endcase
         start = triangles_sent;
         while (triangles_sent - start < 150 && total > 0) begin
            send_fan($urandom_range(1, 6));
            total = total - 1;
         end
      end
   endtask

   task automatic test_backpressure();
      hold_request = 1;
      repeat (6) send_triangle(make_triangle(0, 1));
      wait_drained();
      send_fan(5);
      wait_drained();
   endtask

   // ------------------------------------------------------------ receiver

   initial begin
      int          gap;
      quadric_type want;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, 4);
         if (hold_request) begin
            gap          = 1500;
            hold_request = 0;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         quadrics_seen++;
         if (expected_quadrics.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = expected_quadrics.pop_front();
            for (int i = 0; i < pqa_pkg::NUM_TERMS; i++)
               if (rsp_q[i] !== want.q[i]) begin
                  $error("%s expected %0d got %0d", field_names[i], want.q[i], rsp_q[i]);
                  errors++;
               end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d responses outstanding", expected_quadrics.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_is_degenerate    = 1'b0;
      req_last_triangle    = 1'b0;
      csr_valid            = 1'b0;
      csr_min_cross_length = '0;
      for (int i = 0; i < 9; i++) req_c[i] = '0;
      for (int i = 0; i < pqa_pkg::NUM_TERMS; i++) model_sums[i] = 0;
      model_min_cross = pqa_pkg::MIN_CROSS_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_threshold_extremes();
      test_backpressure();
      test_random_fans(330);
      wait_drained();

      $display("sent %0d triangles, checked %0d quadrics, %0d threshold writes",
               triangles_sent, quadrics_seen, csr_writes);
      if (errors == 0 && expected_quadrics.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pqa_pkg.sv
rtl/plane_quadric_accumulator_top.sv
tb/tb_top.sv
